// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the category code packer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DCCP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dccp assertion failed");

// condition must never be seen outside reset
`define DCCP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `DCCP_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ----- hdl/dccp_pkg.sv -----
// ----------------------------------------------------------------------------
// dccp_pkg
// Types, widths and code tables shared by the category code packer.
// ----------------------------------------------------------------------------
package dccp_pkg;

  localparam int COEF_W      = 12;
  localparam int MAG_W       = 10;
  localparam int CAT_W       = 4;
  localparam int CODE_W      = 18;  // longest prefix (8) plus ten magnitude bits
  localparam int LEN_W       = 5;
  localparam int ACC_W       = 25;  // seven pending bits plus longest code
  localparam int CNT_W       = 5;
  localparam int TOTAL_W     = 24;
  localparam int COUNT_BITS_DEF = 24;
  localparam int QUEUE_DEPTH = 4;   // power of two, pointers wrap naturally

  typedef struct packed {
    logic [CODE_W-1:0] code;   // right aligned
    logic [LEN_W-1:0]  len;
    logic              eos;
    logic              clamp;
  } dccp_code_t;

  function automatic logic [7:0] prefix_code(input logic [CAT_W-1:0] cat);
    logic [7:0] c;
    case (cat)
      4'd0:    c = 8'd2;
      4'd1:    c = 8'd3;
      4'd2:    c = 8'd4;
      4'd3:    c = 8'd0;
      4'd4:    c = 8'd5;
      4'd5:    c = 8'd6;
      4'd6:    c = 8'd14;
      4'd7:    c = 8'd30;
      4'd8:    c = 8'd62;
      4'd9:    c = 8'd126;
      4'd10:   c = 8'd254;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] prefix_len(input logic [CAT_W-1:0] cat);
    logic [LEN_W-1:0] l;
    case (cat)
      4'd3:    l = LEN_W'(2);
      4'd6:    l = LEN_W'(4);
      4'd7:    l = LEN_W'(5);
      4'd8:    l = LEN_W'(6);
      4'd9:    l = LEN_W'(7);
      4'd10:   l = LEN_W'(8);
      default: l = LEN_W'(3);
    endcase
    return l;
  endfunction

endpackage

// ----- hdl/dccp_front.sv -----
// ----------------------------------------------------------------------------
// dccp_front
// Classifies a coefficient: clamp, category, and the right aligned codeword.
// ----------------------------------------------------------------------------
module dccp_front import dccp_pkg::*; (
  input  logic signed [COEF_W-1:0] coefficient,
  input  logic                     end_of_stream,
  output dccp_code_t               item
);

  logic              neg;
  logic [COEF_W-1:0] mag_full;
  logic              clamp;
  logic [MAG_W-1:0]  mag;
  logic [CAT_W-1:0]  cat;
  logic [MAG_W-1:0]  mask;
  logic [MAG_W-1:0]  mbits;

  assign neg      = coefficient[COEF_W-1];
  // -2048 negates to itself, which reads as 2048 unsigned
  assign mag_full = neg ? COEF_W'(-coefficient) : COEF_W'(coefficient);
  assign clamp    = mag_full > COEF_W'(1023);
  assign mag      = clamp ? {MAG_W{1'b1}} : mag_full[MAG_W-1:0];

  always_comb begin
    cat = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag[i]) begin
        cat = CAT_W'(i + 1);
      end
    end
  end

  assign mask  = MAG_W'((11'd1 << cat) - 11'd1);
  assign mbits = (neg ? ~mag : mag) & mask;

  always_comb begin
    item.code  = (CODE_W'(prefix_code(cat)) << cat) | CODE_W'(mbits);
    item.len   = prefix_len(cat) + LEN_W'(cat);
    item.eos   = end_of_stream;
    item.clamp = clamp;
  end

endmodule

// ----- hdl/dccp_queue.sv -----
// ----------------------------------------------------------------------------
// dccp_queue
// Short queue of classified codewords between the front and the packer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dccp_queue import dccp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  dccp_code_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output dccp_code_t rd_data,
  output logic       empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  dccp_code_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full    = count_r == (PTR_W+1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `DCCP_ASSERT(a_count_bound, clk, rst_n, count_r <= (PTR_W+1)'(QUEUE_DEPTH))
  `DCCP_ASSERT_NEVER(a_read_empty, clk, rst_n, rd_en && empty)
  `DCCP_ASSERT_NEVER(a_write_full, clk, rst_n, wr_en && full)

endmodule

// ----- hdl/dccp_back.sv -----
// ----------------------------------------------------------------------------
// dccp_back
// Packs codewords MSB first into bytes, one byte a cycle while the receiver pops, with stream totals.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dccp_back import dccp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dccp_code_t         head,
  input  logic               head_valid,
  output logic               head_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_data_byte,
  output logic               out_run_end,
  output logic               out_stream_end,
  output logic [TOTAL_W-1:0] out_total_bits,
  output logic               out_clamp_seen
);

  // working state: acc_r holds only its low cnt_r bits, the rest is zero
  logic                  busy_r, busy_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  eos_r, eos_nxt;
  logic [COUNT_BITS-1:0] tot_r, tot_nxt;
  logic                  clamp_r, clamp_nxt;

  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_run_end_r;
  logic               out_stream_end_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_clamp_r;

  logic                  out_free;
  logic                  active;
  logic                  step;
  logic [ACC_W-1:0]      w_acc;
  logic [CNT_W-1:0]      w_cnt;
  logic                  w_eos;
  logic [COUNT_BITS-1:0] w_tot;
  logic                  w_clamp;
  logic [COUNT_BITS:0]   tot_sum;
  logic [TOTAL_W-1:0]    w_tot_rep;
  logic                  emit;
  logic                  last;
  logic [7:0]            byte_val;
  logic [CNT_W-1:0]      rem;

  assign out_free = !out_valid_r || out_pop;
  assign active   = busy_r || head_valid;
  assign step     = active && out_free;
  assign head_pop = step && !busy_r;

  assign tot_sum = {1'b0, tot_r} + (COUNT_BITS+1)'(head.len);

  always_comb begin
    if (busy_r) begin
      w_acc   = acc_r;
      w_cnt   = cnt_r;
      w_eos   = eos_r;
      w_tot   = tot_r;
      w_clamp = clamp_r;
    end else begin
      w_acc   = (acc_r << head.len) | ACC_W'(head.code);
      w_cnt   = cnt_r + CNT_W'(head.len);
      w_eos   = head.eos;
      w_tot   = tot_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : tot_sum[COUNT_BITS-1:0];
      w_clamp = clamp_r | head.clamp;
    end
  end

  generate
    if (COUNT_BITS > TOTAL_W) begin : g_sat
      assign w_tot_rep = (|w_tot[COUNT_BITS-1:TOTAL_W]) ? {TOTAL_W{1'b1}}
                                                          : w_tot[TOTAL_W-1:0];
    end else begin : g_ext
      assign w_tot_rep = TOTAL_W'(w_tot);
    end
  endgenerate

  always_comb begin
    emit     = 1'b0;
    last     = 1'b1;
    byte_val = '0;
    rem      = w_cnt;
    if (w_cnt >= CNT_W'(8)) begin
      emit     = 1'b1;
      rem      = w_cnt - CNT_W'(8);
      byte_val = 8'(w_acc >> rem);
      last     = (rem < CNT_W'(8)) && !(w_eos && rem != '0);
    end else if (w_eos && w_cnt != '0) begin
      // zero-padded tail byte
      emit     = 1'b1;
      rem      = '0;
      byte_val = 8'(w_acc[7:0] << (4'd8 - w_cnt[3:0]));
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    eos_nxt   = eos_r;
    tot_nxt   = tot_r;
    clamp_nxt = clamp_r;
    if (step) begin
      busy_nxt  = !last;
      acc_nxt   = w_acc & ((ACC_W'(1) << rem) - ACC_W'(1));
      cnt_nxt   = rem;
      eos_nxt   = w_eos;
      tot_nxt   = w_tot;
      clamp_nxt = w_clamp;
      if (last && w_eos) begin
        acc_nxt   = '0;
        cnt_nxt   = '0;
        tot_nxt   = '0;
        clamp_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
      eos_r       <= 1'b0;
      tot_r       <= '0;
      clamp_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      eos_r   <= eos_nxt;
      tot_r   <= tot_nxt;
      clamp_r <= clamp_nxt;
      if (step && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_byte_r       <= byte_val;
      out_run_end_r    <= last;
      out_stream_end_r <= last && w_eos;
      out_total_r      <= (last && w_eos) ? w_tot_rep : '0;
      out_clamp_r      <= w_clamp;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_data_byte  = out_byte_r;
  assign out_run_end    = out_run_end_r;
  assign out_stream_end = out_stream_end_r;
  assign out_total_bits = out_total_r;
  assign out_clamp_seen = out_clamp_r;

  `DCCP_ASSERT(a_idle_partial, clk, rst_n, !busy_r |-> (cnt_r < CNT_W'(8)))
  `DCCP_ASSERT(a_end_is_last, clk, rst_n, (out_valid_r && out_stream_end_r) |-> out_run_end_r)
  `DCCP_ASSERT(a_total_on_end, clk, rst_n, (out_valid_r && !out_stream_end_r) |-> (out_total_r == '0))

endmodule

// ----- hdl/dc_category_code_packer.sv -----
// An item is taken while the short queue has room; the packer then emits the
// item's bytes one per cycle while the receiver pops (up to three code bytes
// and, at end of stream, one pad byte); an item that completes no byte makes no
// beat. The next item leaves the queue once the last byte of the current one
// enters the single byte-wide output register. Results pop as a queue;
// total_bits is nonzero only on the stream_end beat.
// ----------------------------------------------------------------------------
// dc_category_code_packer
// DC magnitude category encoder packing prefix and magnitude bits into bytes.
// ----------------------------------------------------------------------------
module dc_category_code_packer import dccp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic signed [COEF_W-1:0] in_coefficient,
  input  logic                     in_end_of_stream,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [7:0]               out_data_byte,
  output logic                     out_run_end,
  output logic                     out_stream_end,
  output logic [TOTAL_W-1:0]       out_total_bits,
  output logic                     out_clamp_seen
);

  dccp_code_t item;
  dccp_code_t head;
  logic       q_full;
  logic       q_empty;
  logic       head_pop;

  dccp_front u_front (
    .coefficient   (in_coefficient),
    .end_of_stream (in_end_of_stream),
    .item          (item)
  );

  dccp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push && !q_full),
    .wr_data (item),
    .full    (q_full),
    .rd_en   (head_pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  dccp_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (!q_empty),
    .head_pop       (head_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_data_byte  (out_data_byte),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end),
    .out_total_bits (out_total_bits),
    .out_clamp_seen (out_clamp_seen)
  );

  assign in_full = q_full;

endmodule

// ----- verif/tb_dc_category_code_packer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dc_category_code_packer
// Pushes signed coefficients through the packer: a directed table first, then
// random streams under several idle and stall patterns, including a long
// receiver hold-off. Every output beat is checked field by field against the
// typed expectation or a bit-exact prediction of the prefix and magnitude packing.
// ----------------------------------------------------------------------------
module tb_dc_category_code_packer;
  import dccp_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam int N_DIRECTED      = 25;
  localparam int N_PHASES        = 5;
  localparam int N_PER_PHASE     = 57;

  // bit count saturates at all ones; COUNT_BITS equals the reported width here
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // prefix codes and lengths by category, category 10 first
  localparam logic [10:0][7:0] PREFIX_CODE = {8'd254, 8'd126, 8'd62, 8'd30, 8'd14, 8'd6,
                                              8'd5, 8'd0, 8'd4, 8'd3, 8'd2};
  localparam logic [10:0][3:0] PREFIX_LEN  = {4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3,
                                              4'd3, 4'd2, 4'd3, 4'd3, 4'd3};

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               run_end;
    logic               stream_end;
    logic [TOTAL_W-1:0] total_bits;
    logic               clamp_seen;
  } code_beat_t;

  // n_typed = 0: expectation comes from the predictor
  typedef struct packed {
    logic [COEF_W-1:0]  coef;
    logic               eos;
    logic [1:0]         n_typed;
    logic [23:0]        exp_bytes;  // first byte in the top bits
    logic [TOTAL_W-1:0] total;
    logic               clamp;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic signed [COEF_W-1:0] in_coefficient;
  logic                     in_end_of_stream;
  logic                     out_empty;
  logic                     out_pop;
  logic [7:0]               out_data_byte;
  logic                     out_run_end;
  logic                     out_stream_end;
  logic [TOTAL_W-1:0]       out_total_bits;
  logic                     out_clamp_seen;

  // predictor state
  logic [6:0]         pend_bits    = '0;
  logic [2:0]         pend_cnt     = '0;
  logic [TOTAL_W-1:0] bits_so_far  = '0;
  logic               clamp_sticky = 1'b0;

  code_beat_t fresh_beats[$];
  code_beat_t beats_due[$];
  stim_row_t  directed_rows [N_DIRECTED];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  dc_category_code_packer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_coefficient   (in_coefficient),
    .in_end_of_stream (in_end_of_stream),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_data_byte    (out_data_byte),
    .out_run_end      (out_run_end),
    .out_stream_end   (out_stream_end),
    .out_total_bits   (out_total_bits),
    .out_clamp_seen   (out_clamp_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Encodes one coefficient into fresh_beats and advances the stream state.
  function automatic void pack_coefficient(input logic [COEF_W-1:0] raw, input logic eos);
    logic             neg;
    logic [12:0]      mag;
    int               cat;
    int               cnt;
    int               nb;
    int               i;
    logic [9:0]       mask;
    logic [9:0]       mbits;
    logic [31:0]      acc;
    logic [TOTAL_W:0] sum;
    logic [7:0]       packed_bytes [4];
    code_beat_t       b;
    fresh_beats.delete();
    neg = raw[COEF_W-1];
    mag = neg ? (13'h1000 - {1'b0, raw}) : {1'b0, raw};
    if (mag > 13'd1023) begin
      mag = 13'd1023;
      clamp_sticky = 1'b1;
    end
    cat = 0;
    while (cat < 10 && (mag >> cat) != 0) cat++;
    mask  = 10'((1 << cat) - 1);
    // negative values send the low bits of (value - 1), i.e. the inverted magnitude
    mbits = neg ? (~mag[9:0] & mask) : (mag[9:0] & mask);

    acc = 32'(pend_bits) & ((32'd1 << pend_cnt) - 1);
    acc = (acc << PREFIX_LEN[cat]) | 32'(PREFIX_CODE[cat]);
    acc = (acc << cat) | 32'(mbits);
    cnt = pend_cnt + PREFIX_LEN[cat] + cat;

    sum = {1'b0, bits_so_far} + 25'(PREFIX_LEN[cat] + cat);
    bits_so_far = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    nb = 0;
    while (cnt >= 8) begin
      cnt -= 8;
      packed_bytes[nb] = 8'(acc >> cnt);
      nb++;
    end
    acc = acc & ((32'd1 << cnt) - 1);
    if (eos && cnt > 0) begin
      packed_bytes[nb] = 8'(acc << (8 - cnt));
      nb++;
      cnt = 0;
    end

    for (i = 0; i < nb; i++) begin
      b.data_byte  = packed_bytes[i];
      b.run_end    = (i == nb - 1);
      b.stream_end = b.run_end && eos;
      b.total_bits = b.stream_end ? bits_so_far : '0;
      b.clamp_seen = clamp_sticky;
      fresh_beats.push_back(b);
    end

    if (eos) begin
      pend_bits    = '0;
      pend_cnt     = '0;
      bits_so_far  = '0;
      clamp_sticky = 1'b0;
    end else begin
      pend_bits = acc[6:0];
      pend_cnt  = 3'(cnt);
    end
  endfunction

  // Mostly values spread evenly over the categories, some over-range, some raw.
  function automatic stim_row_t random_row(input logic force_end);
    stim_row_t r;
    int        cat;
    int        mag;
    logic      neg;
    r   = '0;
    neg = $urandom_range(1, 0);
    case ($urandom_range(9, 0))
      0: r.coef = COEF_W'($urandom);
      1: begin
        mag = $urandom_range(2048, 1024);
        if (!neg && mag > 2047) mag = 2047;
        r.coef = neg ? COEF_W'(-mag) : COEF_W'(mag);
      end
      default: begin
        cat = $urandom_range(10, 0);
        mag = (cat == 0) ? 0 : (1 << (cat - 1)) + $urandom_range((1 << (cat - 1)) - 1, 0);
        r.coef = neg ? COEF_W'(-mag) : COEF_W'(mag);
      end
    endcase
    r.eos = force_end || ($urandom_range(7, 0) == 0);
    return r;
  endfunction

  // Entered and left at a falling edge; push stays high between back-to-back beats.
  task automatic offer_row(input stim_row_t r);
    code_beat_t b;
    int         i;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_push = 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_push          = 1'b1;
    in_coefficient   = r.coef;
    in_end_of_stream = r.eos;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pack_coefficient(r.coef, r.eos);
    if (r.n_typed == 0) begin
      foreach (fresh_beats[i]) beats_due.push_back(fresh_beats[i]);
    end else begin
      for (i = 0; i < r.n_typed; i++) begin
        b.data_byte  = r.exp_bytes[23 - 8*i -: 8];
        b.run_end    = (i == r.n_typed - 1);
        b.stream_end = b.run_end && r.eos;
        b.total_bits = b.stream_end ? r.total : '0;
        b.clamp_seen = r.clamp;
        beats_due.push_back(b);
      end
    end
    @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop = 1'b0;
      end else begin
        out_pop = ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    code_beat_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: data_byte %h", out_data_byte);
        mismatch_count++;
      end else begin
        want = beats_due.pop_front();
        if (out_data_byte !== want.data_byte) begin
          $error("data_byte: expected %h, got %h", want.data_byte, out_data_byte);
          mismatch_count++;
        end
        if (out_run_end !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, out_run_end);
          mismatch_count++;
        end
        if (out_stream_end !== want.stream_end) begin
          $error("stream_end: expected %b, got %b", want.stream_end, out_stream_end);
          mismatch_count++;
        end
        if (out_total_bits !== want.total_bits) begin
          $error("total_bits: expected %0d, got %0d", want.total_bits, out_total_bits);
          mismatch_count++;
        end
        if (out_clamp_seen !== want.clamp_seen) begin
          $error("clamp_seen: expected %b, got %b", want.clamp_seen, out_clamp_seen);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_dc_category_code_packer NOT OK");
      $finish;
    end
  end

  initial begin
    int phase;
    int n;
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_coefficient   = '0;
    in_end_of_stream = 1'b0;

    // each typed row starts from a clean stream
    directed_rows = '{
      '{12'sd0,     1'b1, 2'd1, 24'h400000, 24'd3,  1'b0},
      '{12'sd1,     1'b1, 2'd1, 24'h700000, 24'd4,  1'b0},
      '{-12'sd1,    1'b1, 2'd1, 24'h600000, 24'd4,  1'b0},
      '{12'sd3,     1'b1, 2'd1, 24'h980000, 24'd5,  1'b0},
      '{-12'sd4,    1'b1, 2'd1, 24'h180000, 24'd5,  1'b0},
      // exactly one byte: stream ends with nothing pending, no pad
      '{12'sd16,    1'b1, 2'd1, 24'hD00000, 24'd8,  1'b0},
      '{-12'sd31,   1'b1, 2'd1, 24'hC00000, 24'd8,  1'b0},
      '{12'sd1023,  1'b1, 2'd3, 24'hFEFFC0, 24'd18, 1'b0},
      '{-12'sd1023, 1'b1, 2'd3, 24'hFE0000, 24'd18, 1'b0},
      '{12'sd2047,  1'b1, 2'd3, 24'hFEFFC0, 24'd18, 1'b1},
      '{12'h800,    1'b1, 2'd3, 24'hFE0000, 24'd18, 1'b1},  // most negative input
      '{12'sd1024,  1'b1, 2'd3, 24'hFEFFC0, 24'd18, 1'b1},
      // short codes that complete no byte, then a run through categories 0, 2-4 and 6-10
      '{12'sd0,     1'b0, 2'd0, 24'h0, 24'd0, 1'b0},
      '{12'sd0,     1'b0, 2'd0, 24'h0, 24'd0, 1'b0},
      '{12'sd5,     1'b0, 2'd0, 24'h0, 24'd0, 1'b0},
      '{12'sd8,     1'b0, 2'd0, 24'h0, 24'd0, 1'b0},
      '{12'sd40,    1'b0, 2'd0, 24'h0, 24'd0, 1'b0},
      '{-12'sd100,  1'b0, 2'd0, 24'h0, 24'd0, 1'b0},
      '{12'sd200,   1'b0, 2'd0, 24'h0, 24'd0, 1'b0},
      '{12'h800,    1'b0, 2'd0, 24'h0, 24'd0, 1'b0},  // clamp mid-stream, must stick
      '{-12'sd300,  1'b0, 2'd0, 24'h0, 24'd0, 1'b0},
      '{12'sd600,   1'b1, 2'd0, 24'h0, 24'd0, 1'b0},
      '{12'sd0,     1'b0, 2'd0, 24'h0, 24'd0, 1'b0},
      '{12'sd2,     1'b1, 2'd0, 24'h0, 24'd0, 1'b0},  // 3 + 5 bits, no pad
      '{-12'sd2047, 1'b0, 2'd0, 24'h0, 24'd0, 1'b0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (n = 0; n < N_DIRECTED; n++) offer_row(directed_rows[n]);

    for (phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_left      = HOLD_OFF_CYCLES;  // fill the block and stall its input
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        3: begin
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (n = 0; n < N_PER_PHASE; n++)
        offer_row(random_row(phase == N_PHASES - 1 && n == N_PER_PHASE - 1));
    end
    in_push = 1'b0;

    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_dc_category_code_packer OK");
    end else begin
      $display("tb_dc_category_code_packer NOT OK");
    end
    $finish;
  end

endmodule
